// File: rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// Script token lexer package
// Shared constants, codes and character tables of the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int POSITION_BITS_DEF   = 16;
	localparam int KEYWORD_MAX_LEN_DEF = 8;
	localparam int LENGTH_BITS_DEF     = 16;
	localparam int QUEUE_DEPTH         = 4;
	localparam int MAX_RECS            = 3;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_OPER, M_IDENT, M_NUMBER, M_STRING, M_ESCAPE, M_ERROR, M_DONE
	} mode_t;

	localparam logic [1:0] REC_TEXT  = 2'd0;
	localparam logic [1:0] REC_TOKEN = 2'd1;
	localparam logic [1:0] REC_ERROR = 2'd2;

	localparam logic [5:0] K_EOF     = 6'd0;
	localparam logic [5:0] K_IDENT   = 6'd1;
	localparam logic [5:0] K_NUMBER  = 6'd2;
	localparam logic [5:0] K_STRING  = 6'd3;
	localparam logic [5:0] K_MINUS   = 6'd5;
	localparam logic [5:0] K_KW_BASE = 6'd29;
	localparam logic [5:0] K_NONE    = 6'd0;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_UNKNOWN  = 3'd1;
	localparam logic [2:0] E_UNTERM   = 3'd2;
	localparam logic [2:0] E_DOT      = 3'd3;
	localparam logic [2:0] E_ESCAPE   = 3'd4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_USC   = 8'h5F;

	localparam logic [63:0] KW_TEXT [15] = '{
		{"if", 48'h0}, {"else", 32'h0}, {"while", 24'h0}, {"for", 40'h0},
		{"in", 48'h0}, {"return", 16'h0}, "continue", {"break", 24'h0},
		{"and", 40'h0}, {"or", 48'h0}, "function", {"expose", 16'h0},
		{"module", 16'h0}, {"dict", 32'h0}, {"list", 32'h0}
	};
	localparam logic [3:0] KW_LEN [15] = '{
		4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6, 4'd8, 4'd5, 4'd3, 4'd2, 4'd8, 4'd6, 4'd6,
		4'd4, 4'd4
	};

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic [5:0] single_kind(logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h2B: k = 6'd4;
			8'h2A: k = 6'd7;
			8'h2F: k = 6'd8;
			8'h25: k = 6'd9;
			8'h2E: k = 6'd10;
			8'h2C: k = 6'd11;
			8'h28: k = 6'd12;
			8'h29: k = 6'd13;
			8'h7B: k = 6'd14;
			8'h7D: k = 6'd15;
			8'h5B: k = 6'd16;
			8'h5D: k = 6'd17;
			8'h3A: k = 6'd18;
			8'h3B: k = 6'd19;
			8'h5E: k = 6'd28;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] pend_kind(logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h2D: k = 6'd5;
			8'h3D: k = 6'd20;
			8'h21: k = 6'd22;
			8'h3C: k = 6'd24;
			8'h3E: k = 6'd26;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] kw_kind(logic [63:0] w, logic [3:0] n);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = 0; i < 15; i++) begin
			if (n == KW_LEN[i] && w == KW_TEXT[i]) begin
				k = 6'(K_KW_BASE + 6'(i));
			end
		end
		return k;
	endfunction

endpackage

// File: rtl/stl_in_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one source character or the end mark per word.
// ----------------------------------------------------------------------------
interface stl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source(output valid, char_byte, end_of_input, input ready);
	modport sink(input valid, char_byte, end_of_input, output ready);
endinterface

// File: rtl/stl_out_if.sv
// ----------------------------------------------------------------------------
// Record channel
// Valid/ready channel carrying one text, token or error record per word.
// ----------------------------------------------------------------------------
interface stl_out_if #(
	parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               record_type;
	logic [5:0]               token_kind;
	logic [7:0]               text_byte;
	logic [POSITION_BITS-1:0] tok_line;
	logic [POSITION_BITS-1:0] tok_col;
	logic [LENGTH_BITS-1:0]   token_length;
	logic [2:0]               error_code;
	logic                     last_of_run;

	modport source(output valid, record_type, token_kind, text_byte, tok_line,
		tok_col, token_length, error_code, last_of_run, input ready);
	modport sink(input valid, record_type, token_kind, text_byte, tok_line,
		tok_col, token_length, error_code, last_of_run, output ready);
endinterface

// File: rtl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// Script token lexer
// Streaming tokenizer: characters in, text, token and error records out.
// ----------------------------------------------------------------------------
// The chars channel takes one source character per word, or a word with
// end_of_input set that closes the source. The records channel gives the
// records of each character in order, with last_of_run set on the last one;
// a character that yields nothing gives no word.
// A character is taken in every cycle while the four-entry bundle queue has
// room. Its records are written into the bundle queue when it is taken and
// leave from the head of the queue. Output runs one record per cycle while
// the receiver is ready, so characters that yield two or three records can fill the queue.
// When the receiver stalls, records wait in the queue and chars.ready drops
// once it is full. After reset the lexer is between tokens at line 0, column
// 0 with an empty queue. After an error record or the end record, further
// characters are taken and give no records until the next reset.
// ----------------------------------------------------------------------------
module script_token_lexer #(
	parameter int POSITION_BITS   = stl_pkg::POSITION_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEF,
	parameter int LENGTH_BITS     = stl_pkg::LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stl_in_if.sink    chars,
	stl_out_if.source records
);

	localparam int REC_W    = 19 + 2 * POSITION_BITS + LENGTH_BITS;
	localparam int BUNDLE_W = 2 + stl_pkg::MAX_RECS * REC_W;

	logic                push, pop, full, empty;
	logic [BUNDLE_W-1:0] push_data, head;

	stl_front #(
		.POSITION_BITS  (POSITION_BITS),
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
		.LENGTH_BITS    (LENGTH_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars),
		.full  (full),
		.push  (push),
		.bundle(push_data)
	);

	stl_queue #(
		.WIDTH(BUNDLE_W),
		.DEPTH(stl_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	stl_back #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.records(records)
	);

endmodule

// File: rtl/stl_front.sv
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts characters, runs the lexer state and forms a bundle of up to three
// records per character.
// ----------------------------------------------------------------------------
module stl_front #(
	parameter int POSITION_BITS   = stl_pkg::POSITION_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEF,
	parameter int LENGTH_BITS     = stl_pkg::LENGTH_BITS_DEF,
	localparam int REC_W = 19 + 2 * POSITION_BITS + LENGTH_BITS,
	localparam int BUNDLE_W = 2 + stl_pkg::MAX_RECS * REC_W
) (
	input  logic                clk,
	input  logic                arst_n,
	stl_in_if.sink              chars,
	input  logic                full,
	output logic                push,
	output logic [BUNDLE_W-1:0] bundle
);

	localparam int KIDX = $clog2(KEYWORD_MAX_LEN);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;

	typedef struct packed {
		logic [1:0]               rtype;
		logic [5:0]               kind;
		logic [7:0]               tbyte;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] col;
		logic [LENGTH_BITS-1:0]   len;
		logic [2:0]               err;
	} rec_t;

	typedef struct packed {
		logic [1:0]                      cnt;
		rec_t [stl_pkg::MAX_RECS-1:0]    recs;
	} bundle_t;

	stl_pkg::mode_t           mode_q, mode;
	logic [5:0]               pend_q, pend;
	logic [7:0]               win_q [KEYWORD_MAX_LEN];
	logic [7:0]               win [KEYWORD_MAX_LEN];
	logic                     ovf_q, ovf, dot_q, dot;
	logic [7:0]               quote_q, quote;
	logic [POSITION_BITS-1:0] line_q, line, col_q, col, sl_q, sl, sc_q, sc;
	logic [LENGTH_BITS-1:0]   cnt_q, cnt;
	rec_t                     recs [stl_pkg::MAX_RECS];
	logic [1:0]               n;
	logic                     fresh;
	logic [7:0]               c;
	logic                     accept;
	logic [63:0]              win_word;
	logic [5:0]               ident_kind;
	logic [5:0]               k_single, k_pend;
	bundle_t                  bnd;

	function automatic rec_t mk(logic [1:0] t, logic [5:0] k, logic [7:0] b,
		logic [POSITION_BITS-1:0] l, logic [POSITION_BITS-1:0] cl,
		logic [LENGTH_BITS-1:0] ln, logic [2:0] e);
		rec_t r;
		r.rtype = t;
		r.kind  = k;
		r.tbyte = b;
		r.line  = l;
		r.col   = cl;
		r.len   = ln;
		r.err   = e;
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			win_word[63-8*i -: 8] = win_q[i];
		end
		ident_kind = ovf_q ? stl_pkg::K_IDENT :
			stl_pkg::kw_kind(win_word, (cnt_q <= LENGTH_BITS'(8)) ? cnt_q[3:0] : 4'd0);
	end

	assign c        = chars.char_byte;
	assign k_single = stl_pkg::single_kind(c);
	assign k_pend   = stl_pkg::pend_kind(c);
	assign chars.ready = !full;
	assign accept   = chars.valid && !full;

	always_comb begin
		mode  = mode_q;
		pend  = pend_q;
		win   = win_q;
		ovf   = ovf_q;
		dot   = dot_q;
		quote = quote_q;
		line  = line_q;
		col   = col_q;
		sl    = sl_q;
		sc    = sc_q;
		cnt   = cnt_q;
		n     = 2'd0;
		fresh = 1'b0;
		for (int i = 0; i < stl_pkg::MAX_RECS; i++) begin
			recs[i] = '0;
		end
		if (mode_q != stl_pkg::M_ERROR && mode_q != stl_pkg::M_DONE) begin
			if (col != POS_MAX) begin
				col = col + 1'b1;
			end
			if (!chars.end_of_input && c == stl_pkg::CH_NL) begin
				if (line != POS_MAX) begin
					line = line + 1'b1;
				end
				col = '0;
			end
			if (chars.end_of_input) begin
				case (mode_q)
					stl_pkg::M_IDENT: begin
						recs[n] = mk(stl_pkg::REC_TOKEN, ident_kind, 8'd0, sl, sc, cnt,
							stl_pkg::E_NONE);
						n = n + 1'b1;
					end
					stl_pkg::M_NUMBER: begin
						recs[n] = mk(stl_pkg::REC_TOKEN, stl_pkg::K_NUMBER, 8'd0, sl, sc, cnt,
							stl_pkg::E_NONE);
						n = n + 1'b1;
					end
					stl_pkg::M_OPER: begin
						recs[n] = mk(stl_pkg::REC_TOKEN, pend, 8'd0, sl, sc, cnt, stl_pkg::E_NONE);
						n = n + 1'b1;
					end
					stl_pkg::M_STRING, stl_pkg::M_ESCAPE: begin
						recs[n] = mk(stl_pkg::REC_ERROR, stl_pkg::K_EOF, 8'd0, line, col, '0,
							stl_pkg::E_UNTERM);
						n = n + 1'b1;
						mode = stl_pkg::M_ERROR;
					end
					default: begin
					end
				endcase
				if (mode != stl_pkg::M_ERROR) begin
					recs[n] = mk(stl_pkg::REC_TOKEN, stl_pkg::K_EOF, 8'd0, line, col, '0,
						stl_pkg::E_NONE);
					n = n + 1'b1;
					mode = stl_pkg::M_DONE;
				end
			end else begin
				case (mode_q)
					stl_pkg::M_COMMENT: begin
						if (c == stl_pkg::CH_NL) begin
							mode = stl_pkg::M_IDLE;
						end
					end
					stl_pkg::M_OPER: begin
						if (c == ((pend_q == stl_pkg::K_MINUS) ? stl_pkg::CH_GT : stl_pkg::CH_EQ)) begin
							recs[n] = mk(stl_pkg::REC_TOKEN, pend_q + 6'd1, 8'd0, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
							mode = stl_pkg::M_IDLE;
						end else begin
							recs[n] = mk(stl_pkg::REC_TOKEN, pend_q, 8'd0, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
							fresh = 1'b1;
						end
					end
					stl_pkg::M_IDENT: begin
						if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c) || c == stl_pkg::CH_USC ||
							c == stl_pkg::CH_COLON) begin
							if (!ovf && cnt < LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
								win[cnt[KIDX-1:0]] = c;
							end else begin
								ovf = 1'b1;
							end
							if (cnt != LEN_MAX) begin
								cnt = cnt + 1'b1;
							end
							recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_IDENT, c, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
						end else begin
							recs[n] = mk(stl_pkg::REC_TOKEN, ident_kind, 8'd0, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
							fresh = 1'b1;
						end
					end
					stl_pkg::M_NUMBER: begin
						if (stl_pkg::is_digit(c) || (c == stl_pkg::CH_DOT && !dot_q)) begin
							if (c == stl_pkg::CH_DOT) begin
								dot = 1'b1;
							end
							if (cnt != LEN_MAX) begin
								cnt = cnt + 1'b1;
							end
							recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_NUMBER, c, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
						end else if (c == stl_pkg::CH_DOT) begin
							recs[n] = mk(stl_pkg::REC_ERROR, stl_pkg::K_EOF, 8'd0, sl, sc, '0,
								stl_pkg::E_DOT);
							n = n + 1'b1;
							mode = stl_pkg::M_ERROR;
						end else begin
							recs[n] = mk(stl_pkg::REC_TOKEN, stl_pkg::K_NUMBER, 8'd0, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
							fresh = 1'b1;
						end
					end
					stl_pkg::M_STRING: begin
						if (c == quote_q) begin
							recs[n] = mk(stl_pkg::REC_TOKEN, stl_pkg::K_STRING, 8'd0, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
							mode = stl_pkg::M_IDLE;
						end else if (c == stl_pkg::CH_BSL) begin
							mode = stl_pkg::M_ESCAPE;
						end else begin
							if (cnt != LEN_MAX) begin
								cnt = cnt + 1'b1;
							end
							recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, c, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
						end
					end
					stl_pkg::M_ESCAPE: begin
						mode = stl_pkg::M_STRING;
						if (c inside {8'h78, 8'h75, 8'h55}) begin
							recs[n] = mk(stl_pkg::REC_ERROR, stl_pkg::K_EOF, 8'd0, line, col, '0,
								stl_pkg::E_ESCAPE);
							n = n + 1'b1;
							mode = stl_pkg::M_ERROR;
						end else if (c inside {8'h6E, 8'h62, 8'h61, 8'h74, 8'h66, 8'h72, 8'h76,
							stl_pkg::CH_DQ, stl_pkg::CH_SQ, stl_pkg::CH_BSL}) begin
							if (cnt != LEN_MAX) begin
								cnt = cnt + 1'b1;
							end
							case (c)
								8'h6E: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd10, sl,
									sc, cnt, stl_pkg::E_NONE);
								8'h62: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd8, sl,
									sc, cnt, stl_pkg::E_NONE);
								8'h61: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd7, sl,
									sc, cnt, stl_pkg::E_NONE);
								8'h74: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd9, sl,
									sc, cnt, stl_pkg::E_NONE);
								8'h66: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd12, sl,
									sc, cnt, stl_pkg::E_NONE);
								8'h72: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd13, sl,
									sc, cnt, stl_pkg::E_NONE);
								8'h76: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, 8'd11, sl,
									sc, cnt, stl_pkg::E_NONE);
								default: recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, c, sl,
									sc, cnt, stl_pkg::E_NONE);
							endcase
							n = n + 1'b1;
						end else begin
							if (cnt != LEN_MAX) begin
								cnt = cnt + 1'b1;
							end
							recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, stl_pkg::CH_BSL, sl,
								sc, cnt, stl_pkg::E_NONE);
							n = n + 1'b1;
							if (cnt != LEN_MAX) begin
								cnt = cnt + 1'b1;
							end
							recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_STRING, c, sl, sc, cnt,
								stl_pkg::E_NONE);
							n = n + 1'b1;
						end
					end
					default: begin
						fresh = 1'b1;
					end
				endcase
			end
			if (fresh) begin
				mode = stl_pkg::M_IDLE;
				if (c == stl_pkg::CH_HASH) begin
					mode = stl_pkg::M_COMMENT;
				end else if (c != stl_pkg::CH_SPACE && c != stl_pkg::CH_TAB &&
					c != stl_pkg::CH_NL) begin
					sl  = line;
					sc  = col;
					cnt = '0;
					if (k_single != stl_pkg::K_NONE) begin
						recs[n] = mk(stl_pkg::REC_TOKEN, k_single, 8'd0, sl, sc, cnt,
							stl_pkg::E_NONE);
						n = n + 1'b1;
					end else if (k_pend != stl_pkg::K_NONE) begin
						pend = k_pend;
						mode = stl_pkg::M_OPER;
					end else if (c == stl_pkg::CH_DQ || c == stl_pkg::CH_SQ) begin
						quote = c;
						mode  = stl_pkg::M_STRING;
					end else if (stl_pkg::is_digit(c)) begin
						dot  = 1'b0;
						mode = stl_pkg::M_NUMBER;
						cnt  = LENGTH_BITS'(1);
						recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_NUMBER, c, sl, sc, cnt,
							stl_pkg::E_NONE);
						n = n + 1'b1;
					end else if (stl_pkg::is_alpha(c) || c == stl_pkg::CH_USC) begin
						for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
							win[i] = 8'd0;
						end
						win[0] = c;
						ovf  = 1'b0;
						mode = stl_pkg::M_IDENT;
						cnt  = LENGTH_BITS'(1);
						recs[n] = mk(stl_pkg::REC_TEXT, stl_pkg::K_IDENT, c, sl, sc, cnt,
							stl_pkg::E_NONE);
						n = n + 1'b1;
					end else begin
						recs[n] = mk(stl_pkg::REC_ERROR, stl_pkg::K_EOF, 8'd0, line, col, '0,
							stl_pkg::E_UNKNOWN);
						n = n + 1'b1;
						mode = stl_pkg::M_ERROR;
					end
				end
			end
		end
	end

	always_comb begin
		bnd.cnt = n;
		for (int i = 0; i < stl_pkg::MAX_RECS; i++) begin
			bnd.recs[i] = recs[i];
		end
	end

	assign bundle = bnd;
	assign push   = accept && n != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stl_pkg::M_IDLE;
			pend_q  <= '0;
			ovf_q   <= 1'b0;
			dot_q   <= 1'b0;
			quote_q <= '0;
			line_q  <= '0;
			col_q   <= '0;
			sl_q    <= '0;
			sc_q    <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			mode_q  <= mode;
			pend_q  <= pend;
			ovf_q   <= ovf;
			dot_q   <= dot;
			quote_q <= quote;
			line_q  <= line;
			col_q   <= col;
			sl_q    <= sl;
			sc_q    <= sc;
			cnt_q   <= cnt;
			win_q   <= win;
		end
	end

endmodule

// File: rtl/stl_queue.sv
// ----------------------------------------------------------------------------
// Bundle queue
// Small register queue that decouples the lexer front end from the record
// output stage.
// ----------------------------------------------------------------------------
module stl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = stl_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output logic [WIDTH-1:0] head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/stl_back.sv
// ----------------------------------------------------------------------------
// Record output stage
// Sends the records of the bundle at the head of the queue one word at a time.
// ----------------------------------------------------------------------------
module stl_back #(
	parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF,
	localparam int REC_W = 19 + 2 * POSITION_BITS + LENGTH_BITS,
	localparam int BUNDLE_W = 2 + stl_pkg::MAX_RECS * REC_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  logic [BUNDLE_W-1:0] head,
	output logic                pop,
	stl_out_if.source           records
);

	typedef struct packed {
		logic [1:0]               rtype;
		logic [5:0]               kind;
		logic [7:0]               tbyte;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] col;
		logic [LENGTH_BITS-1:0]   len;
		logic [2:0]               err;
	} rec_t;

	typedef struct packed {
		logic [1:0]                   cnt;
		rec_t [stl_pkg::MAX_RECS-1:0] recs;
	} bundle_t;

	bundle_t    bnd;
	rec_t       rec;
	logic [1:0] idx_q;
	logic       last;

	assign bnd  = head;
	assign rec  = bnd.recs[idx_q];
	assign last = idx_q == bnd.cnt - 2'd1;
	assign pop  = records.valid && records.ready && last;

	assign records.valid        = !empty;
	assign records.record_type  = rec.rtype;
	assign records.token_kind   = rec.kind;
	assign records.text_byte    = rec.tbyte;
	assign records.tok_line     = rec.line;
	assign records.tok_col      = rec.col;
	assign records.token_length = rec.len;
	assign records.error_code   = rec.err;
	assign records.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (records.valid && records.ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
